>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the palette frame text encoder
// Opcodes, register indexes, character codes, byte slot layout and the
// record passed from the palette read stage to the byte serializer.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // palette geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam int PAL_DW          = 24;

    // field and register widths
    localparam int CFG_W  = 11;
    localparam int POS_W  = 10;

    // input opcodes
    localparam logic [1:0] OP_PAL_WR = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_SOF    = 2'd2;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // register reset values and clamp limits
    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd200;
    localparam logic [CFG_W-1:0] WIDTH_MIN  = 11'd2;
    localparam logic [CFG_W-1:0] HEIGHT_MIN = 11'd4;
    localparam logic [CFG_W-1:0] DIM_MAX    = 11'd1024;

    // character codes
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_M      = 8'h6d;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    // level bias added to each channel
    localparam logic [8:0] CHAN_BIAS = 9'd32;

    // last color code value meaning nothing sent yet
    localparam logic [3:0] CODE_NONE = 4'hf;

    // byte slots of one run, in output order
    localparam int NUM_SLOTS   = 19;
    localparam int SLOT_C_ESC  = 0;
    localparam int SLOT_C_LBR  = 1;
    localparam int SLOT_C_HUND = 2;
    localparam int SLOT_C_TENS = 3;
    localparam int SLOT_C_ONES = 4;
    localparam int SLOT_C_SEMI = 5;
    localparam int SLOT_C_ONE  = 6;
    localparam int SLOT_C_H    = 7;
    localparam int SLOT_B_ESC  = 8;
    localparam int SLOT_B_LBR  = 9;
    localparam int SLOT_B_FOUR = 10;
    localparam int SLOT_B_CODE = 11;
    localparam int SLOT_B_M    = 12;
    localparam int SLOT_F_ESC  = 13;
    localparam int SLOT_F_LBR  = 14;
    localparam int SLOT_F_THR  = 15;
    localparam int SLOT_F_CODE = 16;
    localparam int SLOT_F_M    = 17;
    localparam int SLOT_CHAR   = 18;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;

    // kept pixel, as handed from the front stage to the serializer
    typedef struct packed {
        logic       head;      // first kept pixel of a kept row
        logic       hund_en;
        logic       tens_en;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [5:0] glyph;     // color index / 4
        logic       in_range;  // index lies inside the palette
    } pix_req_t;

endpackage

>>> rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram: generic single-clock RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pfa_front.sv
// ----------------------------------------------------------------------------
// pfa_front: input decode, raster position and palette access
// Tracks column and row, decides which pixels are kept, writes and reads
// the palette RAM, and works out the decimal digits of the line number.
// ----------------------------------------------------------------------------
module pfa_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [7:0]                 s_color_index,
    input  logic [7:0]                 s_red,
    input  logic [7:0]                 s_green,
    input  logic [7:0]                 s_blue,
    input  logic [pfa_pkg::CFG_W-1:0]  width_eff,
    input  logic [pfa_pkg::CFG_W-1:0]  height_eff,
    input  logic                       s1_ready,
    output logic                       s1_valid,
    output pfa_pkg::pix_req_t          s1_req,
    output logic [pfa_pkg::PAL_DW-1:0] rd_data
);
    import pfa_pkg::*;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             s1_valid_reg, s1_valid_next;
    pix_req_t         s1_req_reg;

    logic             acc;
    logic             is_pixel;
    logic             kept;
    logic [CFG_W-1:0] col_p1;
    logic [CFG_W-1:0] row_p1;
    logic [CFG_W-1:0] row_p3;
    logic             in_range;
    logic             pal_we;
    logic             pal_re;
    pix_req_t         req;

    // line number digits
    logic [8:0]       line_num;
    logic [1:0]       hund;
    logic [8:0]       hund_x100;
    logic [8:0]       rem9;
    logic [6:0]       rem7;
    logic [14:0]      tens_prod;
    logic [3:0]       tens;
    logic [6:0]       tens_x10;
    logic [6:0]       ones7;

    assign s_ready  = s1_ready;
    assign acc      = s_valid & s1_ready;
    assign is_pixel = (s_opcode == OP_PIXEL);

    // keep even columns of every fourth row, dropping partial tails
    assign col_p1 = {1'b0, col_reg} + 11'd1;
    assign row_p1 = {1'b0, row_reg} + 11'd1;
    assign row_p3 = {1'b0, row_reg} + 11'd3;
    assign kept   = is_pixel && !col_reg[0] && (col_p1 < width_eff)
                    && (row_reg[1:0] == 2'b00) && (row_p3 < height_eff);

    assign in_range = ({1'b0, s_color_index} < 9'(PALETTE_ENTRIES));
    assign pal_we   = acc && (s_opcode == OP_PAL_WR) && in_range;
    assign pal_re   = acc && kept;

    pfa_ram #(
        .WIDTH (PAL_DW),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .wr_addr (s_color_index[PAL_AW-1:0]),
        .wr_data ({s_red, s_green, s_blue}),
        .rd_en   (pal_re),
        .rd_addr (s_color_index[PAL_AW-1:0]),
        .rd_data (rd_data)
    );

    // decimal digits of row/4 + 1 (at most 256)
    always_comb begin
        line_num = {1'b0, row_reg[POS_W-1:2]} + 9'd1;
        if (line_num >= 9'd200) begin
            hund      = 2'd2;
            hund_x100 = 9'd200;
        end else if (line_num >= 9'd100) begin
            hund      = 2'd1;
            hund_x100 = 9'd100;
        end else begin
            hund      = 2'd0;
            hund_x100 = 9'd0;
        end
        rem9      = line_num - hund_x100;
        rem7      = rem9[6:0];
        // x / 10 as (x * 205) >> 11, exact below 1029
        tens_prod = 15'(rem7) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = 7'(tens) * 7'd10;
        ones7     = rem7 - tens_x10;
    end

    always_comb begin
        req.head     = (col_reg == '0);
        req.hund_en  = (line_num >= 9'd100);
        req.tens_en  = (line_num >= 9'd10);
        req.hund     = hund;
        req.tens     = tens;
        req.ones     = ones7[3:0];
        req.glyph    = s_color_index[7:2];
        req.in_range = in_range;
    end

    // raster position update
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc) begin
            if (s_opcode == OP_SOF) begin
                col_next = '0;
                row_next = '0;
            end else if (is_pixel) begin
                if (col_p1 >= width_eff) begin
                    col_next = '0;
                    row_next = (row_p1 >= height_eff) ? '0 : row_p1[POS_W-1:0];
                end else begin
                    col_next = col_p1[POS_W-1:0];
                end
            end
        end
    end

    // stage register toward the serializer
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready) begin
            s1_valid_next = pal_re;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_re) begin
            s1_req_reg <= req;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_req   = s1_req_reg;

    // a stalled kept pixel keeps its record
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_ready |=> s1_valid_reg && $stable(s1_req_reg))
        else $error("front: stalled record changed");

    // every accepted kept pixel reaches the stage register
    assert property (@(posedge aclk) disable iff (!aresetn)
        pal_re |=> s1_valid_reg)
        else $error("front: kept pixel lost");

    // start of frame returns to the origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        acc && (s_opcode == OP_SOF) |=> (col_reg == '0) && (row_reg == '0))
        else $error("front: start of frame did not clear position");

endmodule

>>> rtl/pfa_ser.sv
// ----------------------------------------------------------------------------
// pfa_ser: color code tracking and byte serializer
// Derives background and foreground codes from the palette word, compares
// them with the last codes sent, and streams the bytes of one run.
// ----------------------------------------------------------------------------
module pfa_ser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s1_valid,
    output logic                       s1_ready,
    input  pfa_pkg::pix_req_t          s1_req,
    input  logic [pfa_pkg::PAL_DW-1:0] rd_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_text_byte,
    output logic                       m_last_of_run
);
    import pfa_pkg::*;

    slot_mask_t  mask_reg, mask_next;
    logic [3:0]  last_bg_reg, last_bg_next;
    logic [3:0]  last_fg_reg, last_fg_next;
    logic [1:0]  hund_reg;
    logic [3:0]  tens_reg;
    logic [3:0]  ones_reg;
    logic [2:0]  bg_reg;
    logic [2:0]  fg_reg;
    logic [5:0]  glyph_reg;

    logic [PAL_DW-1:0] entry;
    logic [8:0]  r9, g9, b9;
    logic [2:0]  bg, fg;
    logic        bg_chg, fg_chg;
    slot_mask_t  new_mask;
    slot_mask_t  cur;
    slot_mask_t  rest;
    logic        free;
    logic        load;
    logic [7:0]  slot_byte [NUM_SLOTS];
    logic [7:0]  out_byte;

    // color codes from biased channel levels
    always_comb begin
        entry  = s1_req.in_range ? rd_data : '0;
        r9     = {1'b0, entry[23:16]} + CHAN_BIAS;
        g9     = {1'b0, entry[15:8]}  + CHAN_BIAS;
        b9     = {1'b0, entry[7:0]}   + CHAN_BIAS;
        bg     = {b9[7], g9[7], r9[7]};
        fg     = {b9[6], g9[6], r9[6]};
        bg_chg = ({1'b0, bg} != last_bg_reg);
        fg_chg = ({1'b0, fg} != last_fg_reg);
    end

    // slots used by this run
    always_comb begin
        new_mask = '0;
        new_mask[SLOT_C_ESC]  = s1_req.head;
        new_mask[SLOT_C_LBR]  = s1_req.head;
        new_mask[SLOT_C_HUND] = s1_req.head & s1_req.hund_en;
        new_mask[SLOT_C_TENS] = s1_req.head & s1_req.tens_en;
        new_mask[SLOT_C_ONES] = s1_req.head;
        new_mask[SLOT_C_SEMI] = s1_req.head;
        new_mask[SLOT_C_ONE]  = s1_req.head;
        new_mask[SLOT_C_H]    = s1_req.head;
        new_mask[SLOT_B_ESC]  = bg_chg;
        new_mask[SLOT_B_LBR]  = bg_chg;
        new_mask[SLOT_B_FOUR] = bg_chg;
        new_mask[SLOT_B_CODE] = bg_chg;
        new_mask[SLOT_B_M]    = bg_chg;
        new_mask[SLOT_F_ESC]  = fg_chg;
        new_mask[SLOT_F_LBR]  = fg_chg;
        new_mask[SLOT_F_THR]  = fg_chg;
        new_mask[SLOT_F_CODE] = fg_chg;
        new_mask[SLOT_F_M]    = fg_chg;
        new_mask[SLOT_CHAR]   = 1'b1;
    end

    // lowest pending slot is the current word
    assign cur     = mask_reg & (~mask_reg + 1'b1);
    assign rest    = mask_reg & ~cur;
    assign m_valid = (mask_reg != '0);
    assign free    = (mask_reg == '0) || (m_ready && (rest == '0));
    assign load    = s1_valid && free;
    assign s1_ready = !s1_valid || free;

    always_comb begin
        slot_byte[SLOT_C_ESC]  = CH_ESC;
        slot_byte[SLOT_C_LBR]  = CH_LBRACK;
        slot_byte[SLOT_C_HUND] = CH_ZERO + {6'b0, hund_reg};
        slot_byte[SLOT_C_TENS] = CH_ZERO + {4'b0, tens_reg};
        slot_byte[SLOT_C_ONES] = CH_ZERO + {4'b0, ones_reg};
        slot_byte[SLOT_C_SEMI] = CH_SEMI;
        slot_byte[SLOT_C_ONE]  = CH_ONE;
        slot_byte[SLOT_C_H]    = CH_H;
        slot_byte[SLOT_B_ESC]  = CH_ESC;
        slot_byte[SLOT_B_LBR]  = CH_LBRACK;
        slot_byte[SLOT_B_FOUR] = CH_FOUR;
        slot_byte[SLOT_B_CODE] = CH_ZERO + {5'b0, bg_reg};
        slot_byte[SLOT_B_M]    = CH_M;
        slot_byte[SLOT_F_ESC]  = CH_ESC;
        slot_byte[SLOT_F_LBR]  = CH_LBRACK;
        slot_byte[SLOT_F_THR]  = CH_THREE;
        slot_byte[SLOT_F_CODE] = CH_ZERO + {5'b0, fg_reg};
        slot_byte[SLOT_F_M]    = CH_M;
        slot_byte[SLOT_CHAR]   = CH_ZERO + {2'b0, glyph_reg};
    end

    // one-hot select of the current byte
    always_comb begin
        out_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (cur[i]) begin
                out_byte = out_byte | slot_byte[i];
            end
        end
    end

    assign m_text_byte   = out_byte;
    assign m_last_of_run = m_valid && (rest == '0);

    // run state and last codes
    always_comb begin
        mask_next    = mask_reg;
        last_bg_next = last_bg_reg;
        last_fg_next = last_fg_reg;
        if (load) begin
            mask_next    = new_mask;
            last_bg_next = {1'b0, bg};
            last_fg_next = {1'b0, fg};
        end else if (m_valid && m_ready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            last_bg_reg <= CODE_NONE;
            last_fg_reg <= CODE_NONE;
        end else begin
            mask_reg    <= mask_next;
            last_bg_reg <= last_bg_next;
            last_fg_reg <= last_fg_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hund_reg  <= s1_req.hund;
            tens_reg  <= s1_req.tens;
            ones_reg  <= s1_req.ones;
            bg_reg    <= bg;
            fg_reg    <= fg;
            glyph_reg <= s1_req.glyph;
        end
    end

    // each run ends with the pixel character
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> mask_reg[SLOT_CHAR])
        else $error("ser: run without pixel character");

    // a loaded pixel becomes the reference for the next compare
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (last_bg_reg == {1'b0, $past(bg)}) && (last_fg_reg == {1'b0, $past(fg)}))
        else $error("ser: last codes not updated");

    // a run continues until its last word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("ser: run cut short");

endmodule

>>> rtl/palette_frame_to_ansi_text_encoder.sv
// ----------------------------------------------------------------------------
// palette_frame_to_ansi_text_encoder: indexed pixels to terminal text
// Keeps a palette and raster position, samples every second column of every
// fourth row and emits cursor, color and character bytes for kept pixels.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    opcode, color_index, red, green, blue
//   m_       out        m_valid/m_ready    text_byte, last_of_run
//   cfg_     in         cfg_wr_en          cfg_addr, cfg_wr_data
//
// An input word is taken every cycle while the serializer can absorb it; a
// kept pixel yields 1 to 19 bytes, one per cycle, so the sustained input rate
// is set by the byte count of each run at the single-byte output port.
// Palette word and pixel record register on acceptance; the serializer loads
// the run once free. Reset is synchronous; the palette RAM is not cleared and
// needs no clearing pass. An output stall holds the run and back-pressures.
// ----------------------------------------------------------------------------
module palette_frame_to_ansi_text_encoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [7:0]                s_color_index,
    input  logic [7:0]                s_red,
    input  logic [7:0]                s_green,
    input  logic [7:0]                s_blue,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_text_byte,
    output logic                      m_last_of_run,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [pfa_pkg::CFG_W-1:0] cfg_wr_data
);
    import pfa_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [CFG_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;

    logic              s1_valid;
    logic              s1_ready;
    pix_req_t          s1_req;
    logic [PAL_DW-1:0] rd_data;

    // configuration registers
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WIDTH:  width_next  = cfg_wr_data;
                REG_HEIGHT: height_next = cfg_wr_data;
                default:    width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // clamp to the supported frame size
    always_comb begin
        if (width_reg < WIDTH_MIN) begin
            width_eff = WIDTH_MIN;
        end else if (width_reg > DIM_MAX) begin
            width_eff = DIM_MAX;
        end else begin
            width_eff = width_reg;
        end
        if (height_reg < HEIGHT_MIN) begin
            height_eff = HEIGHT_MIN;
        end else if (height_reg > DIM_MAX) begin
            height_eff = DIM_MAX;
        end else begin
            height_eff = height_reg;
        end
    end

    pfa_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_color_index (s_color_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .width_eff     (width_eff),
        .height_eff    (height_eff),
        .s1_ready      (s1_ready),
        .s1_valid      (s1_valid),
        .s1_req        (s1_req),
        .rd_data       (rd_data)
    );

    pfa_ser u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_req        (s1_req),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_text_byte   (m_text_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the palette frame to terminal text encoder
// Drives palette writes, pixels and frame starts over valid/ready, writes the
// frame size registers between phases and compares every output word against
// a predictor that tracks palette, raster position and last color codes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    // opcode the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
    } text_char_t;

    // predictor and store of expected text words
    class text_scoreboard;
        logic [PAL_DW-1:0] palette [PALETTE_ENTRIES];
        int                col;
        int                row;
        logic [3:0]        last_bg;
        logic [3:0]        last_fg;
        int                width_reg;
        int                height_reg;
        text_char_t        pending_q [$];
        int                errors;

        function new();
            foreach (palette[i]) palette[i] = '0;
            col        = 0;
            row        = 0;
            last_bg    = CODE_NONE;
            last_fg    = CODE_NONE;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic addr, logic [CFG_W-1:0] data);
            if (addr == REG_WIDTH) width_reg = data;
            else height_reg = data;
        endfunction

        function int clamp(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // note one accepted input word and queue the text it causes
        function void note_word(logic [1:0] op, logic [7:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int          w;
            int          h;
            int          line;
            logic [23:0] entry;
            logic [8:0]  rs;
            logic [8:0]  gs;
            logic [8:0]  bs;
            logic [3:0]  bg;
            logic [3:0]  fg;
            logic [7:0]  run [$];
            text_char_t  item;
            w = clamp(width_reg, WIDTH_MIN, DIM_MAX);
            h = clamp(height_reg, HEIGHT_MIN, DIM_MAX);
            case (op)
                OP_PAL_WR: begin
                    if (idx < PALETTE_ENTRIES) palette[idx] = {r, g, b};
                    return;
                end
                OP_SOF: begin
                    col = 0;
                    row = 0;
                    return;
                end
                OP_PIXEL: ;
                default: return;
            endcase

            // kept pixel: even column of a row that is a multiple of four
            if (col % 2 == 0 && col + 1 < w && row % 4 == 0 && row + 3 < h) begin
                entry = (idx < PALETTE_ENTRIES) ? palette[idx] : '0;
                rs = entry[23:16] + CHAN_BIAS;
                gs = entry[15:8] + CHAN_BIAS;
                bs = entry[7:0] + CHAN_BIAS;
                bg = {1'b0, bs[7], gs[7], rs[7]};
                fg = {1'b0, bs[6], gs[6], rs[6]};
                if (col == 0) begin
                    line = row / 4 + 1;
                    run.push_back(CH_ESC);
                    run.push_back(CH_LBRACK);
                    if (line >= 100) run.push_back(8'(CH_ZERO + line / 100));
                    if (line >= 10) run.push_back(8'(CH_ZERO + (line / 10) % 10));
                    run.push_back(8'(CH_ZERO + line % 10));
                    run.push_back(CH_SEMI);
                    run.push_back(CH_ONE);
                    run.push_back(CH_H);
                end
                if (bg != last_bg) begin
                    run.push_back(CH_ESC);
                    run.push_back(CH_LBRACK);
                    run.push_back(CH_FOUR);
                    run.push_back(8'(CH_ZERO + bg));
                    run.push_back(CH_M);
                    last_bg = bg;
                end
                if (fg != last_fg) begin
                    run.push_back(CH_ESC);
                    run.push_back(CH_LBRACK);
                    run.push_back(CH_THREE);
                    run.push_back(8'(CH_ZERO + fg));
                    run.push_back(CH_M);
                    last_fg = fg;
                end
                run.push_back(8'(CH_ZERO + idx[7:2]));
                foreach (run[i]) begin
                    item.ch   = run[i];
                    item.tail = (i == run.size() - 1);
                    pending_q.push_back(item);
                end
            end

            // raster advance
            if (col + 1 >= w) begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
                col = col + 1;
            end
        endfunction

        // compare one output word with the oldest expectation
        function void check_byte(logic [7:0] ch, logic tail);
            text_char_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: byte %h last %b", ch, tail);
                return;
            end
            want = pending_q.pop_front();
            if (want.ch !== ch || want.tail !== tail) begin
                errors++;
                if (errors <= 10)
                    $display("word mismatch: expected byte %h last %b, got byte %h last %b",
                             want.ch, want.tail, ch, tail);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_opcode;
    logic [7:0]       s_color_index;
    logic [7:0]       s_red;
    logic [7:0]       s_green;
    logic [7:0]       s_blue;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_text_byte;
    logic             m_last_of_run;
    logic             cfg_wr_en;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wr_data;

    text_scoreboard sb;
    bit             quiet;
    bit             stall_req;
    bit             filled [PALETTE_ENTRIES];
    logic [7:0]     filled_q [$];

    palette_frame_to_ansi_text_encoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_color_index (s_color_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_text_byte   (m_text_byte),
        .m_last_of_run (m_last_of_run),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random back-pressure, quiet stretches and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                stall_req = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // monitor: outputs first, then the accepted input word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_byte(m_text_byte, m_last_of_run);
            if (s_valid && s_ready)
                sb.note_word(s_opcode, s_color_index, s_red, s_green, s_blue);
        end
    end

    // offer one word, with an optional random gap ahead of it
    task automatic send_word(logic [1:0] op, logic [7:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!quiet && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_color_index <= idx;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_palette(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b);
        if (!filled[idx]) begin
            filled[idx] = 1'b1;
            filled_q.push_back(idx);
        end
        send_word(OP_PAL_WR, idx, r, g, b);
    endtask

    task automatic send_pixel(logic [7:0] idx);
        send_word(OP_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic cfg_write(logic addr, logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= data;
        sb.write_reg(addr, data);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // stop offering and wait for every expected word, then let the pipe settle;
    // the wait starts only once the last accepted word has been noted
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly raster pixels from written entries, some writes, frame starts, noise
    task automatic random_word(int sof_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < sof_pct)
            send_word(OP_SOF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < sof_pct + 2)
            send_word(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (roll < sof_pct + 12)
            write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_pixel(filled_q[$urandom_range(filled_q.size() - 1)]);
    endtask

    task automatic run_phase(int w, int h, int count, int sof_pct, bit quiet_en,
                             bit hold_en);
        drain();
        cfg_write(REG_WIDTH, CFG_W'(w));
        cfg_write(REG_HEIGHT, CFG_W'(h));
        quiet = quiet_en;
        send_word(OP_SOF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        if (hold_en) stall_req = 1'b1;
        repeat (count) random_word(sof_pct);
    endtask

    // main sequence
    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_PAL_WR;
        s_color_index = '0;
        s_red         = '0;
        s_green       = '0;
        s_blue        = '0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_WIDTH;
        cfg_wr_data   = '0;
        quiet         = 1'b0;
        stall_req     = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset frame size
        write_palette(8'd0,   8'd0,   8'd0,   8'd0);     // all low levels
        write_palette(8'd255, 8'd255, 8'd255, 8'd255);   // bias carries into bit 8
        write_palette(8'd85,  8'd96,  8'd31,  8'd32);    // levels that just reach or just miss bit 7 or bit 6
        write_palette(8'd170, 8'd95,  8'd224, 8'd160);
        write_palette(8'd3,   8'd200, 8'd100, 8'd150);
        send_word(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff); // ignored
        send_pixel(8'd0);     // first pixel of row: cursor and both codes
        send_pixel(8'd85);    // odd column, dropped
        send_pixel(8'd85);    // both codes change
        send_pixel(8'd170);
        send_pixel(8'd170);
        send_pixel(8'd255);
        send_pixel(8'd255);   // highest glyph
        send_pixel(8'd3);
        send_pixel(8'd3);
        send_pixel(8'd85);    // odd column, dropped
        send_word(OP_SOF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(8'd85);    // cursor again after frame start
        send_pixel(8'd0);

        // widest row clamped from above, height clamped from below, no idling
        run_phase(2047, 3, 50, 0, 1'b1, 1'b0);
        // narrowest width clamped, tall frame: two digit line numbers
        run_phase(0, 2047, 100, 0, 1'b0, 1'b0);
        // odd width and height not a multiple of four
        run_phase(7, 10, 70, 4, 1'b0, 1'b0);
        // receiver holds off while the sender keeps offering
        run_phase(16, 12, 80, 3, 1'b0, 1'b1);
        run_phase(2, 4, 40, 5, 1'b1, 1'b0);
        run_phase(1, 1025, 40, 3, 1'b0, 1'b0);
        run_phase(1024, 1024, 30, 2, 1'b0, 1'b0);
        run_phase(11, 21, 50, 4, 1'b0, 1'b0);

        drain();
        if (sb.pending_q.size() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_front.sv
rtl/pfa_ser.sv
rtl/palette_frame_to_ansi_text_encoder.sv
bench/tb.sv
